/* src/tdrf_pkg.sv */
`default_nettype none
package tdrf_pkg;

  localparam logic OP_RX    = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [7:0] BYTE_HOLD_ON  = 8'hFF;
  localparam logic [7:0] BYTE_HOLD_OFF = 8'hFE;
  localparam logic [7:0] BYTE_FRAME    = 8'hF0;
  localparam logic [3:0] NIB_FRAME     = 4'hF;
  localparam logic [7:0] MAX_PAYLOAD   = 8'd255;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_LEN  = 3'b010,
    PH_PAY  = 3'b100
  } parse_ph_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_HDR   = 5'b00100,
    ST_LEN   = 5'b01000,
    ST_BODY  = 5'b10000
  } ctrl_st_t;

  typedef struct packed {
    logic rx;
    logic load;
    logic start;
    logic app_hdr;
    logic app_len;
    logic app_body;
    logic run;
  } tdrf_cmd_t;

  typedef struct packed {
    logic skip;
    logic app_ok;
    logic rd_avail;
    logic body_end;
  } tdrf_sts_t;

endpackage
`default_nettype wire

/* src/tdrf_if.sv */
`default_nettype none
interface tdrf_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [3:0] drain_tunnel;
  modport source (output valid, op, rx_byte, drain_tunnel, input ready);
  modport sink (input valid, op, rx_byte, drain_tunnel, output ready);
endinterface

interface tdrf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_word;
  logic [3:0]  byte_count;
  logic        last_of_frame;
  logic        hold_flag;
  modport source (output valid, frame_word, byte_count, last_of_frame, hold_flag,
                  input ready);
  modport sink (input valid, frame_word, byte_count, last_of_frame, hold_flag,
                output ready);
endinterface
`default_nettype wire

/* src/tunnel_demux_ring_framer_unit.sv */
`default_nettype none
// Tunnel demultiplexer and ring framer.
// in_if carries one item per handshake: op 0 hands over one received stream
// byte, op 1 asks for one frame to be drained from tunnel drain_tunnel.
// Stream bytes are taken one per cycle while no drain runs and never give a
// result; payload bytes land in the tunnel's ring in the same cycle unless
// the ring is full or the tunnel unknown. A drain first checks the tunnel
// (empty or unknown tunnels end there with no result), then moves the frame
// (header, length, L payload bytes) into out_if at one byte per cycle while
// out_if does not stall, limited by the ring memory's single read port.
// out_if items carry up to eight bytes, so a drain of L bytes gives
// ceil((L+2)/8) items. The next input item is taken only once the drain has
// ended, also after an empty or unknown tunnel.
// A result register sits in front of out_if: while out_if stalls, the
// frame pauses at the end of the next word, and stream bytes are still taken
// whenever no drain is running.
// Reset (synchronous, rst_n low) empties all rings, returns the parser to
// command phase and clears the hold flag; ring contents are not cleared.
module tunnel_demux_ring_framer_unit #(
  parameter int TUNNELS     = 4,
  parameter int QUEUE_BYTES = 4096
) (
  input wire logic   clk,
  input wire logic   rst_n,
  tdrf_in_if.sink    in_if,
  tdrf_out_if.source out_if
);
  import tdrf_pkg::*;

  tdrf_cmd_t cmd;
  tdrf_sts_t sts;
  logic      in_ready;

  assign in_if.ready = in_ready;

  tdrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_if.op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tdrf_dpath #(
    .TUNNELS     (TUNNELS),
    .QUEUE_BYTES (QUEUE_BYTES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_rx_byte        (in_if.rx_byte),
    .in_drain_tunnel   (in_if.drain_tunnel),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_frame_word    (out_if.frame_word),
    .out_byte_count    (out_if.byte_count),
    .out_last_of_frame (out_if.last_of_frame),
    .out_hold_flag     (out_if.hold_flag)
  );

  // a drain request blocks further items while it runs
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_ready && in_if.op == OP_DRAIN |=> !in_ready)
    else $error("input taken right after a drain request");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> out_if.byte_count != 4'd0 && out_if.byte_count <= 4'd8)
    else $error("result item byte count out of range");

  // only the final word of a frame may be short
  a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.last_of_frame |-> out_if.byte_count == 4'd8)
    else $error("short word inside a frame");

  a_no_rx_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> !cmd.rx && !cmd.load)
    else $error("stream byte taken while a frame is moving");

endmodule
`default_nettype wire

/* src/tdrf_ctrl.sv */
`default_nettype none
module tdrf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_op,
  output logic                   in_ready,
  output tdrf_pkg::tdrf_cmd_t    cmd,
  input  wire tdrf_pkg::tdrf_sts_t sts
);
  import tdrf_pkg::*;

  ctrl_st_t st_r, st_nxt;

  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_ready = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_op == OP_RX) begin
          cmd.rx = 1'b1;
        end else if (in_valid && in_op == OP_DRAIN) begin
          cmd.load = 1'b1;
          st_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.skip) begin
          st_nxt = ST_IDLE;
        end else begin
          cmd.start = 1'b1;
          st_nxt    = ST_HDR;
        end
      end
      ST_HDR: begin
        cmd.app_hdr = 1'b1;
        cmd.run     = 1'b1;
        if (sts.app_ok) st_nxt = ST_LEN;
      end
      ST_LEN: begin
        cmd.app_len = 1'b1;
        cmd.run     = 1'b1;
        if (sts.app_ok) st_nxt = ST_BODY;
      end
      ST_BODY: begin
        cmd.app_body = 1'b1;
        cmd.run      = 1'b1;
        if (sts.app_ok && sts.rd_avail && sts.body_end) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/tdrf_dpath.sv */
`default_nettype none
module tdrf_dpath #(
  parameter int TUNNELS     = 4,
  parameter int QUEUE_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tdrf_pkg::tdrf_cmd_t cmd,
  output tdrf_pkg::tdrf_sts_t      sts,
  input  wire logic [7:0]          in_rx_byte,
  input  wire logic [3:0]          in_drain_tunnel,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [63:0]              out_frame_word,
  output logic [3:0]               out_byte_count,
  output logic                     out_last_of_frame,
  output logic                     out_hold_flag
);
  import tdrf_pkg::*;

  localparam int PW        = $clog2(QUEUE_BYTES);
  localparam int TW        = (TUNNELS > 1) ? $clog2(TUNNELS) : 1;
  localparam int AW        = TW + PW;
  localparam int MEM_DEPTH = TUNNELS << PW;
  localparam logic [PW:0]   QB       = (PW + 1)'(QUEUE_BYTES);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_BYTES - 1);
  localparam logic [4:0]    TUN_LIM  = 5'(TUNNELS);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // parser state
  parse_ph_t  phase_r, phase_nxt;
  logic [3:0] active_r, active_nxt;
  logic [7:0] left_r, left_nxt;
  logic       hold_r, hold_nxt;
  logic       push;

  // rings
  logic [PW-1:0] wp_r [TUNNELS];
  logic [PW-1:0] rp_r [TUNNELS];
  logic [7:0]    store_r [MEM_DEPTH];

  // drain side
  logic [3:0]  dtun_r;
  logic [7:0]  rd_data_r;
  logic        rdv_r;
  logic [7:0]  issue_left_r;
  logic [7:0]  body_left_r;
  logic [63:0] asm_r;
  logic [2:0]  asm_cnt_r;

  // result register
  logic        out_valid_r;
  logic [63:0] out_word_r;
  logic [3:0]  out_cnt_r;
  logic        out_last_r;
  logic        out_hold_r;

  logic [3:0]    sel_tun;
  logic          sel_ok;
  logic [TW-1:0] sel_idx;
  logic [PW-1:0] wp_sel, rp_sel, wp_inc;
  logic          full;
  logic [PW:0]   diff, held_w;
  logic [16:0]   held_x;
  logic [7:0]    held_cap;

  logic        out_free, app_last, word_end, app_ok, consume, app_fire, flush, issue;
  logic [7:0]  app_b, hdr_b;
  logic [63:0] word_all;

  assign sel_tun = cmd.rx ? active_r : dtun_r;
  assign sel_ok  = {1'b0, sel_tun} < TUN_LIM;
  assign sel_idx = sel_tun[TW-1:0];
  assign wp_sel  = wp_r[sel_idx];
  assign rp_sel  = rp_r[sel_idx];
  assign wp_inc  = ring_next(wp_sel);
  assign full    = (wp_inc == rp_sel);

  assign diff     = {1'b0, wp_sel} - {1'b0, rp_sel};
  assign held_w   = (wp_sel >= rp_sel) ? diff : diff + QB;
  assign held_x   = 17'(held_w);
  assign held_cap = (held_x > 17'(MAX_PAYLOAD)) ? MAX_PAYLOAD : held_x[7:0];

  // stream parser
  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    left_nxt   = left_r;
    hold_nxt   = hold_r;
    push       = 1'b0;
    if (cmd.rx) begin
      case (phase_r)
        PH_LEN: begin
          left_nxt  = in_rx_byte;
          phase_nxt = (in_rx_byte == 8'd0) ? PH_IDLE : PH_PAY;
        end
        PH_PAY: begin
          push = sel_ok && !full;
          if (left_r != 8'd0) left_nxt = left_r - 8'd1;
          if (left_r <= 8'd1) phase_nxt = PH_IDLE;
        end
        PH_IDLE: begin
          if (in_rx_byte == BYTE_HOLD_ON) begin
            hold_nxt = 1'b1;
          end else if (in_rx_byte == BYTE_HOLD_OFF) begin
            hold_nxt = 1'b0;
          end else if (in_rx_byte[7:4] == NIB_FRAME) begin
            active_nxt = in_rx_byte[3:0];
            left_nxt   = 8'd0;
            phase_nxt  = PH_LEN;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // frame assembly, one byte per cycle while out_if does not stall, into an eight-byte word
  assign out_free = !out_valid_r || out_ready;
  assign app_last = cmd.app_body && (body_left_r == 8'd1);
  assign word_end = (asm_cnt_r == 3'd7) || app_last;
  assign app_ok   = !word_end || out_free;
  assign consume  = cmd.app_body && app_ok && rdv_r;
  assign app_fire = ((cmd.app_hdr || cmd.app_len) && app_ok) || consume;
  assign flush    = app_fire && word_end;
  assign hdr_b    = BYTE_FRAME | {4'h0, dtun_r};
  assign app_b    = cmd.app_hdr ? hdr_b : (cmd.app_len ? body_left_r : rd_data_r);
  assign word_all = asm_r | (64'(app_b) << {asm_cnt_r, 3'b000});
  assign issue    = cmd.run && (issue_left_r != 8'd0) && (!rdv_r || consume);

  assign sts.skip     = !sel_ok || (held_w == '0);
  assign sts.app_ok   = app_ok;
  assign sts.rd_avail = rdv_r;
  assign sts.body_end = (body_left_r == 8'd1);

  always_ff @(posedge clk) begin
    if (push) store_r[AW'({sel_idx, wp_sel})] <= in_rx_byte;
    if (issue) rd_data_r <= store_r[AW'({sel_idx, rp_sel})];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      active_r     <= '0;
      left_r       <= '0;
      hold_r       <= 1'b0;
      for (int i = 0; i < TUNNELS; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
      dtun_r       <= '0;
      rdv_r        <= 1'b0;
      issue_left_r <= '0;
      body_left_r  <= '0;
      asm_r        <= '0;
      asm_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      active_r <= active_nxt;
      left_r   <= left_nxt;
      hold_r   <= hold_nxt;
      if (push) wp_r[sel_idx] <= wp_inc;
      if (issue) rp_r[sel_idx] <= ring_next(rp_sel);
      if (cmd.load) dtun_r <= in_drain_tunnel;

      if (cmd.start) begin
        issue_left_r <= held_cap;
        body_left_r  <= held_cap;
      end else begin
        if (issue) issue_left_r <= issue_left_r - 8'd1;
        if (consume) body_left_r <= body_left_r - 8'd1;
      end

      if (issue) begin
        rdv_r <= 1'b1;
      end else if (consume) begin
        rdv_r <= 1'b0;
      end

      if (flush) begin
        asm_r     <= '0;
        asm_cnt_r <= '0;
      end else if (app_fire) begin
        asm_r     <= word_all;
        asm_cnt_r <= asm_cnt_r + 3'd1;
      end

      if (flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      out_word_r <= word_all;
      out_cnt_r  <= {1'b0, asm_cnt_r} + 4'd1;
      out_last_r <= app_last;
      out_hold_r <= hold_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_word    = out_word_r;
  assign out_byte_count    = out_cnt_r;
  assign out_last_of_frame = out_last_r;
  assign out_hold_flag     = out_hold_r;

endmodule
`default_nettype wire
